// ===== src/dpg_pkg.sv =====
`default_nettype none
package dpg_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ILK_PRESENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TANK_FILL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_RATE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TANK_VOLUME = 3'd5;

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_STOP     = 3'd2;
	localparam logic [2:0] OP_RESET_RT = 3'd3;
	localparam logic [2:0] OP_CLR_ERR  = 3'd4;

	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_EST  = 2'd1;

	localparam logic [31:0] RST_MAX_RUN     = 32'd0;
	localparam logic [13:0] RST_TANK_FILL   = 14'd10000;
	localparam logic [15:0] RST_FLOW_RATE   = 16'd1500;
	localparam logic [23:0] RST_TANK_VOLUME = 24'd20000;

	// Fill margin of 5 percent, and the fill that passes when usage counts as -1 percent.
	localparam logic [13:0] FILL_MARGIN   = 14'd500;
	localparam logic [13:0] FILL_OFF_LIM  = 14'd400;

	// Milliseconds per hour over centipercent scaling: 3600000 / 10000.
	localparam int SCALE_W = 23;
	localparam logic [SCALE_W-1:0] SCALE_K = 23'd360;

	localparam int QUO_W     = 47;
	localparam int CNT_W     = $clog2(QUO_W);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] now_ms;
		logic        running_sense;
		logic        level_switch;
		logic        interlock_good;
	} in_word_t;

	typedef struct packed {
		logic        accepted;
		logic        pump_drive;
		logic        overtime_error;
		logic        tank_ok;
		logic [31:0] run_time_ms;
	} out_word_t;

	typedef struct packed {
		logic [31:0] max_run_time_ms;
		logic [1:0]  level_mode;
		logic        interlock_present;
		logic [13:0] tank_fill_centipct;
		logic [15:0] flow_rate_mlh;
		logic [23:0] tank_volume_ml;
	} cfg_t;

	typedef struct packed {
		logic             busy;
		logic [QUO_W-1:0] quo;
		logic             rem_nz;
	} thr_t;

	typedef enum logic [1:0] {
		THR_SCALE,
		THR_MUL,
		THR_DIV,
		THR_IDLE
	} thr_state_t;

endpackage
`default_nettype wire

// ===== src/dpg_thr.sv =====
`default_nettype none
module dpg_thr (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          restart,
	input  dpg_pkg::cfg_t cfg,
	output dpg_pkg::thr_t thr
);
	import dpg_pkg::*;

	thr_state_t       state_q;
	thr_state_t       state_n;
	logic [SCALE_W-1:0] scaled_q;
	logic [QUO_W-1:0] dvd_q;
	logic [15:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [13:0]      fill_m;
	logic [16:0]      rem_sh;
	logic             ge;

	assign fill_m = cfg.tank_fill_centipct - FILL_MARGIN;
	assign rem_sh = {rem_q, dvd_q[QUO_W-1]};
	assign ge     = rem_sh >= {1'b0, cfg.flow_rate_mlh};

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			THR_SCALE: state_n = THR_MUL;
			THR_MUL:   state_n = THR_DIV;
			THR_DIV: begin
				if (cnt_q == '0) begin
					state_n = THR_IDLE;
				end
			end
			THR_IDLE:  state_n = THR_IDLE;
			default:   state_n = THR_SCALE;
		endcase
		if (restart) begin
			state_n = THR_SCALE;
		end
	end

	always_comb begin
		thr.busy   = (state_q != THR_IDLE);
		thr.quo    = dvd_q;
		thr.rem_nz = (rem_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= THR_SCALE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			THR_SCALE: begin
				scaled_q <= SCALE_W'(fill_m) * SCALE_K;
			end
			THR_MUL: begin
				dvd_q <= QUO_W'(scaled_q) * QUO_W'(cfg.tank_volume_ml);
				rem_q <= '0;
				cnt_q <= DIV_LAST;
			end
			THR_DIV: begin
				dvd_q <= {dvd_q[QUO_W-2:0], ge};
				rem_q <= ge ? 16'(rem_sh - {1'b0, cfg.flow_rate_mlh}) : rem_sh[15:0];
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/dpg_core.sv =====
`default_nettype none
module dpg_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  dpg_pkg::in_word_t  word,
	input  dpg_pkg::cfg_t      cfg,
	input  dpg_pkg::thr_t      thr,
	input  logic               lim_load,
	input  logic [31:0]        lim_value,
	output dpg_pkg::out_word_t result
);
	import dpg_pkg::*;

	logic [31:0] rt_q, ss_q, lim_q;
	logic        err_q, drv_q;
	logic [31:0] rt_n, ss_n, lim_n;
	logic        err_n, drv_n, acc;
	logic [31:0] delta, rt_add, rt_tick;
	logic        sensed, ilk_bad, hit, tok_now, tok_tick;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic tank_ok_f(input logic [31:0] rt, input logic lsw,
			input cfg_t c, input thr_t t);
		logic est;
		if (c.flow_rate_mlh == '0 || c.tank_volume_ml == '0) begin
			est = c.tank_fill_centipct > FILL_OFF_LIM;
		end else if (c.tank_fill_centipct <= FILL_MARGIN) begin
			est = 1'b0;
		end else begin
			est = (QUO_W'(rt) < t.quo) || (QUO_W'(rt) == t.quo && t.rem_nz);
		end
		if (c.level_mode == LVL_NONE) begin
			return 1'b1;
		end else if (c.level_mode == LVL_EST) begin
			return est;
		end
		return lsw;
	endfunction

	always_comb begin
		sensed   = word.running_sense;
		ilk_bad  = cfg.interlock_present & ~word.interlock_good;
		delta    = word.now_ms - ss_q;
		rt_add   = sat_add(rt_q, delta);
		rt_tick  = sensed ? rt_add : rt_q;
		hit      = (lim_q != '0) && (rt_tick >= lim_q);
		tok_now  = tank_ok_f(rt_q, word.level_switch, cfg, thr);
		tok_tick = tank_ok_f(rt_tick, word.level_switch, cfg, thr);

		rt_n  = rt_q;
		ss_n  = ss_q;
		lim_n = lim_q;
		err_n = err_q;
		drv_n = drv_q;
		acc   = 1'b0;
		unique case (word.opcode)
			OP_TICK: begin
				rt_n = rt_tick;
				if (sensed) begin
					ss_n = word.now_ms;
				end
				if (hit) begin
					err_n = 1'b1;
				end
				if (sensed && (hit || !tok_tick || ilk_bad)) begin
					drv_n = 1'b0;
				end
			end
			OP_START: begin
				if (!sensed && !err_q && tok_now && !ilk_bad) begin
					drv_n = 1'b1;
					ss_n  = word.now_ms;
					acc   = 1'b1;
				end
			end
			OP_STOP: begin
				if (sensed) begin
					drv_n = 1'b0;
					rt_n  = rt_add;
					acc   = 1'b1;
				end
			end
			OP_RESET_RT: begin
				rt_n  = '0;
				ss_n  = '0;
				lim_n = cfg.max_run_time_ms;
			end
			OP_CLR_ERR: begin
				if (err_q) begin
					lim_n = sat_add(lim_q, cfg.max_run_time_ms);
					err_n = 1'b0;
				end
			end
			default: begin
			end
		endcase

		result.accepted       = acc;
		result.pump_drive     = drv_n;
		result.overtime_error = err_n;
		result.tank_ok        = tank_ok_f(rt_n, word.level_switch, cfg, thr);
		result.run_time_ms    = rt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q  <= '0;
			ss_q  <= '0;
			lim_q <= RST_MAX_RUN;
			err_q <= 1'b0;
			drv_q <= 1'b0;
		end else begin
			if (adv) begin
				rt_q  <= rt_n;
				ss_q  <= ss_n;
				err_q <= err_n;
				drv_q <= drv_n;
			end
			if (lim_load) begin
				lim_q <= lim_value;
			end else if (adv) begin
				lim_q <= lim_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/dosing_pump_runtime_guard.sv =====
`default_nettype none
// Dosing pump run-time guard. One command word enters per clock while cmd_stall is low; each
// word is held in an input register, evaluated combinationally against the guard state, and its
// response word is captured in an output register; with no stall the sustained rate is one word
// per cycle. The input register can still take one word while a response waits on rsp_stall,
// and then stalls. The tank estimate compares run time against a threshold that a bit-serial
// divider derives from the configuration: after reset and after every configuration write,
// cmd_stall stays high through one scaling step, one multiply step, then 47 divide steps, one
// quotient bit per cycle. Configuration writes are always taken and must only be issued while
// no command word is in flight.
module dosing_pump_runtime_guard (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  dpg_pkg::in_word_t                 cmd,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output dpg_pkg::out_word_t                rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dpg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);
	import dpg_pkg::*;

	cfg_t      cfg_q;
	thr_t      thr;
	in_word_t  cmd_s1;
	logic      valid_s1;
	out_word_t rsp_q;
	logic      rsp_valid_q;
	out_word_t result;
	logic      cfg_wr, lim_load, adv, take;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign lim_load  = cfg_wr && (cfg_index == CFG_MAX_RUN);

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = thr.busy || (valid_s1 && !adv);
	assign take      = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_run_time_ms    <= RST_MAX_RUN;
			cfg_q.level_mode         <= LVL_NONE;
			cfg_q.interlock_present  <= 1'b0;
			cfg_q.tank_fill_centipct <= RST_TANK_FILL;
			cfg_q.flow_rate_mlh      <= RST_FLOW_RATE;
			cfg_q.tank_volume_ml     <= RST_TANK_VOLUME;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_MAX_RUN:     cfg_q.max_run_time_ms    <= cfg_data;
				CFG_LEVEL_MODE:  cfg_q.level_mode         <= cfg_data[1:0];
				CFG_ILK_PRESENT: cfg_q.interlock_present  <= cfg_data[0];
				CFG_TANK_FILL:   cfg_q.tank_fill_centipct <= cfg_data[13:0];
				CFG_FLOW_RATE:   cfg_q.flow_rate_mlh      <= cfg_data[15:0];
				CFG_TANK_VOLUME: cfg_q.tank_volume_ml     <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	dpg_thr u_thr (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.cfg     (cfg_q),
		.thr     (thr)
	);

	dpg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.word      (cmd_s1),
		.cfg       (cfg_q),
		.thr       (thr),
		.lim_load  (lim_load),
		.lim_value (cfg_data),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
		if (adv) begin
			rsp_q <= result;
		end
	end

	// Only a start or a stop can report that it took effect.
	a_acc_op: assert property (@(posedge clk) disable iff (!arst_n)
		adv && result.accepted |-> cmd_s1.opcode == OP_START || cmd_s1.opcode == OP_STOP)
		else $error("accepted set for a command other than start or stop");

	// A start that took effect leaves the pump driven and no error pending.
	a_start_drive: assert property (@(posedge clk) disable iff (!arst_n)
		adv && result.accepted && cmd_s1.opcode == OP_START
		|-> result.pump_drive && !result.overtime_error)
		else $error("accepted start without drive or with error");

	// Resetting run time reports zero run time in the response that follows.
	a_reset_rt: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1.opcode == OP_RESET_RT |=> rsp_valid && rsp.run_time_ms == '0)
		else $error("run time not cleared by reset command");

	// No new word enters while the tank threshold is being recomputed.
	a_thr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		thr.busy && !$past(valid_s1) |-> !valid_s1)
		else $error("word entered during threshold computation");

endmodule
`default_nettype wire

// ===== tb/sv/dosing_pump_runtime_guard_tb.sv =====
module dosing_pump_runtime_guard_tb;
	import dpg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [1:0] LVL_SWITCH = 2'd2;
	localparam logic [1:0] LVL_SWITCH_ALT = 2'd3;
	localparam logic [13:0] FILL_PASS_NO_EST = 14'd400;
	localparam logic [13:0] FILL_RESERVE = 14'd500;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_WORDS = 212;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]          data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	in_word_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	out_word_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	in_word_t cmd_backlog[$];
	reg_write_t reg_writes[$];
	out_word_t due_q[$];

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	bit squeeze = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int mismatches = 0;
	int rsp_seen = 0;
	int quiet = 0;
	int phase_items = 0;
	logic [31:0] stamp = '0;

	logic [31:0] set_max_run = RST_MAX_RUN;
	logic [1:0]  set_mode = LVL_NONE;
	logic        set_ilk_used = 1'b0;
	logic [13:0] set_fill = RST_TANK_FILL;
	logic [15:0] set_flow = RST_FLOW_RATE;
	logic [23:0] set_vol = RST_TANK_VOLUME;

	logic [31:0] pump_run_time = '0;
	logic [31:0] pump_start = '0;
	logic [31:0] pump_limit = RST_MAX_RUN;
	logic        pump_error = 1'b0;
	logic        pump_drive = 1'b0;

	dosing_pump_runtime_guard u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic tank_sufficient(logic lsw);
		logic [63:0] reserve;
		logic [63:0] used;
		if (set_mode == LVL_NONE)
			return 1'b1;
		if (set_mode != LVL_EST)
			return lsw;
		if (set_flow == 0 || set_vol == 0)
			return set_fill > FILL_PASS_NO_EST;
		if (set_fill <= FILL_RESERVE)
			return 1'b0;
		reserve = 64'(set_fill - FILL_RESERVE) * 64'd360 * 64'(set_vol);
		used = 64'(set_flow) * 64'(pump_run_time);
		return reserve > used;
	endfunction

	function automatic logic halt_pump(in_word_t w);
		if (!w.running_sense)
			return 1'b0;
		pump_drive = 1'b0;
		pump_run_time = sat_add32(pump_run_time, w.now_ms - pump_start);
		return 1'b1;
	endfunction

	function automatic out_word_t pump_guard_next(in_word_t w);
		out_word_t r;
		logic ilk_bad;
		logic took;
		ilk_bad = set_ilk_used && !w.interlock_good;
		took = 1'b0;
		case (w.opcode)
			OP_TICK: begin
				if (w.running_sense) begin
					pump_run_time = sat_add32(pump_run_time, w.now_ms - pump_start);
					pump_start = w.now_ms;
				end
				if (pump_limit != 0 && pump_run_time >= pump_limit) begin
					void'(halt_pump(w));
					pump_error = 1'b1;
				end
				if (!tank_sufficient(w.level_switch))
					void'(halt_pump(w));
				if (ilk_bad)
					void'(halt_pump(w));
			end
			OP_START: begin
				if (!w.running_sense && !pump_error && tank_sufficient(w.level_switch)
						&& !ilk_bad) begin
					pump_drive = 1'b1;
					pump_start = w.now_ms;
					took = 1'b1;
				end
			end
			OP_STOP: begin
				took = halt_pump(w);
			end
			OP_RESET_RT: begin
				pump_start = '0;
				pump_run_time = '0;
				pump_limit = set_max_run;
			end
			OP_CLR_ERR: begin
				if (pump_error) begin
					pump_limit = sat_add32(pump_limit, set_max_run);
					pump_error = 1'b0;
				end
			end
			default: begin
			end
		endcase
		r.accepted = took;
		r.pump_drive = pump_drive;
		r.overtime_error = pump_error;
		r.tank_ok = tank_sufficient(w.level_switch);
		r.run_time_ms = pump_run_time;
		return r;
	endfunction

	function automatic void load_setting(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			CFG_MAX_RUN: begin
				set_max_run = data;
				pump_limit = data;
			end
			CFG_LEVEL_MODE: set_mode = data[1:0];
			CFG_ILK_PRESENT: set_ilk_used = data[0];
			CFG_TANK_FILL: set_fill = data[13:0];
			CFG_FLOW_RATE: set_flow = data[15:0];
			CFG_TANK_VOLUME: set_vol = data[23:0];
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk) begin : drive_words
		reg_write_t rw;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				load_setting(cfg_index, cfg_data);
			if (!cfg_valid || cfg_ready) begin
				if (reg_writes.size() != 0) begin
					rw = reg_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= rw.idx;
					cfg_data <= rw.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
			if (cmd_valid && !cmd_stall)
				due_q.push_back(pump_guard_next(cmd));
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					cmd <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_words
		out_word_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response word %0d arrived with nothing due", rsp_seen);
				end else begin
					want = due_q.pop_front();
					if (rsp.accepted !== want.accepted || rsp.pump_drive !== want.pump_drive
							|| rsp.overtime_error !== want.overtime_error
							|| rsp.tank_ok !== want.tank_ok
							|| rsp.run_time_ms !== want.run_time_ms) begin
						mismatches++;
						if (mismatches <= 10)
							$display("response word %0d: expected acc=%b drive=%b err=%b tank=%b run=%h",
								rsp_seen, want.accepted, want.pump_drive, want.overtime_error,
								want.tank_ok, want.run_time_ms,
								"  got acc=%b drive=%b err=%b tank=%b run=%h",
								rsp.accepted, rsp.pump_drive, rsp.overtime_error,
								rsp.tank_ok, rsp.run_time_ms);
					end
				end
			end
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (squeeze && !hold_done) begin
				rsp_stall <= 1'b1;
				hold_left <= 300;
				hold_done <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic put(logic [2:0] op, logic [31:0] now, logic sense, logic lsw, logic ilk);
		in_word_t w;
		w.opcode = op;
		w.now_ms = now;
		w.running_sense = sense;
		w.level_switch = lsw;
		w.interlock_good = ilk;
		cmd_backlog.push_back(w);
		phase_items++;
	endtask

	task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		reg_write_t rw;
		rw.idx = idx;
		rw.data = data;
		reg_writes.push_back(rw);
	endtask

	function automatic logic [31:0] pad(logic [31:0] v, int w);
		logic [31:0] junk;
		junk = $urandom;
		if ($urandom_range(3) != 0)
			return v;
		return v | (junk << w);
	endfunction

	task automatic drain();
		while (cmd_backlog.size() != 0 || cmd_valid || due_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_config(logic [31:0] max_run, logic [1:0] mode, logic ilk,
			logic [13:0] fill, logic [15:0] flow, logic [23:0] vol);
		drain();
		push_reg(CFG_MAX_RUN, max_run);
		push_reg(CFG_LEVEL_MODE, pad(32'(mode), 2));
		push_reg(CFG_ILK_PRESENT, pad(32'(ilk), 1));
		push_reg(CFG_TANK_FILL, pad(32'(fill), 14));
		push_reg(CFG_FLOW_RATE, pad(32'(flow), 16));
		push_reg(CFG_TANK_VOLUME, pad(32'(vol), 24));
		while (reg_writes.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	task automatic random_config();
		logic [31:0] max_run;
		logic [1:0] mode;
		logic [13:0] fill;
		logic [15:0] flow;
		logic [23:0] vol;
		case ($urandom_range(3))
			0: max_run = '0;
			1: max_run = 32'hFFFF_FFFF;
			2: max_run = $urandom_range(20000, 1);
			default: max_run = $urandom;
		endcase
		mode = $urandom_range(1) ? LVL_EST : 2'($urandom_range(3));
		case ($urandom_range(8))
			0: fill = '0;
			1: fill = FILL_PASS_NO_EST;
			2: fill = FILL_PASS_NO_EST + 14'd1;
			3: fill = FILL_RESERVE;
			4: fill = FILL_RESERVE + 14'd1;
			5: fill = '1;
			6: fill = RST_TANK_FILL;
			7: fill = 14'($urandom);
			default: fill = 14'($urandom_range(10000, 501));
		endcase
		case ($urandom_range(5))
			0: flow = '0;
			1: flow = '1;
			default: flow = 16'($urandom);
		endcase
		case ($urandom_range(5))
			0: vol = '0;
			1: vol = '1;
			2, 3: vol = 24'($urandom_range(2000, 1));
			default: vol = 24'($urandom);
		endcase
		set_config(max_run, mode, 1'($urandom_range(1)), fill, flow, vol);
	endtask

	function automatic logic [31:0] next_stamp();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			stamp = stamp + $urandom_range(200, 1);
		else if (r < 95)
			stamp = stamp + $urandom_range(100000);
		else
			stamp = stamp + $urandom;
		return stamp;
	endfunction

	function automatic logic noisy(logic b);
		return ($urandom_range(9) == 0) ? !b : b;
	endfunction

	function automatic logic mostly_set();
		return $urandom_range(9) != 0;
	endfunction

	task automatic add_session();
		int n;
		int r;
		n = $urandom_range(8, 1);
		put(OP_START, next_stamp(), noisy(1'b0), mostly_set(), mostly_set());
		repeat (n)
			put(OP_TICK, next_stamp(), noisy(1'b1), mostly_set(), mostly_set());
		r = $urandom_range(9);
		if (r < 6)
			put(OP_STOP, next_stamp(), noisy(1'b1), mostly_set(), mostly_set());
		else if (r == 6)
			put(OP_CLR_ERR, next_stamp(), noisy(1'b0), mostly_set(), mostly_set());
		else if (r == 7)
			put(OP_RESET_RT, next_stamp(), noisy(1'b0), mostly_set(), mostly_set());
		if ($urandom_range(4) == 0)
			put(OP_CLR_ERR, next_stamp(), noisy(1'b0), mostly_set(), mostly_set());
	endtask

	initial begin : run_test
		int p;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put(OP_TICK, 32'd0, 1'b0, 1'b0, 1'b0);

		// Estimate mode with a tiny tank: it runs dry after 100 ms of run time.
		set_config(32'd0, LVL_EST, 1'b1, 14'd600, 16'd36000, 24'd100);
		put(OP_START, 32'd1000, 1'b0, 1'b1, 1'b1);
		put(OP_TICK, 32'd1040, 1'b1, 1'b1, 1'b1);
		put(OP_TICK, 32'd1100, 1'b1, 1'b1, 1'b1);
		put(OP_START, 32'd1200, 1'b0, 1'b1, 1'b1);
		put(OP_RESET_RT, 32'd1300, 1'b0, 1'b1, 1'b1);
		put(OP_START, 32'd1400, 1'b0, 1'b1, 1'b0);
		put(OP_START, 32'd1500, 1'b1, 1'b1, 1'b1);
		put(OP_START, 32'd2000, 1'b0, 1'b1, 1'b1);
		put(OP_TICK, 32'd2010, 1'b1, 1'b1, 1'b0);
		put(OP_STOP, 32'd2020, 1'b0, 1'b1, 1'b1);
		put(OP_STOP, 32'd2050, 1'b1, 1'b1, 1'b1);
		put(OP_CLR_ERR, 32'd2060, 1'b0, 1'b1, 1'b1);

		// Short run limit across a timestamp wrap, then recovery from the overtime error.
		set_config(32'd100, LVL_NONE, 1'b0, 14'd0, 16'd0, 24'd0);
		put(OP_START, 32'hFFFF_FFC0, 1'b0, 1'b0, 1'b0);
		put(OP_TICK, 32'h0000_0010, 1'b1, 1'b0, 1'b0);
		put(OP_START, 32'd20, 1'b0, 1'b1, 1'b1);
		put(OP_CLR_ERR, 32'd30, 1'b0, 1'b1, 1'b1);
		put(OP_TICK, 32'd40, 1'b0, 1'b0, 1'b0);
		put(OP_FIRST_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		put(OP_FIRST_UNUSED + 3'd1, 32'h0, 1'b0, 1'b0, 1'b0);
		put(OP_FIRST_UNUSED + 3'd2, 32'hA5A5_5A5A, 1'b1, 1'b0, 1'b1);

		// Level switch mode with the largest limit: run time and limit both saturate.
		set_config(32'hFFFF_FFFF, LVL_SWITCH, 1'b1, 14'h3FFF, 16'hFFFF, 24'hFF_FFFF);
		put(OP_START, 32'd100, 1'b0, 1'b0, 1'b1);
		put(OP_START, 32'd0, 1'b0, 1'b1, 1'b1);
		put(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		put(OP_CLR_ERR, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
		put(OP_TICK, 32'h0000_0001, 1'b1, 1'b1, 1'b1);

		set_config(32'd0, LVL_SWITCH_ALT, 1'b0, FILL_PASS_NO_EST, 16'd0, 24'd1234);
		put(OP_START, 32'd500, 1'b0, 1'b0, 1'b0);

		for (p = 0; p < 8; p++) begin
			drain();
			if (p == 2) begin
				push_reg(CFG_SPARE_LO, $urandom);
				push_reg(CFG_SPARE_HI, $urandom);
			end
			random_config();
			case (p % 4)
				0: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 0;
				end
				1: begin
					snd_idle_pct = 50;
					rcv_stall_pct = 0;
				end
				2: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 50;
				end
				default: begin
					snd_idle_pct = 13;
					rcv_stall_pct = 13;
				end
			endcase
			squeeze = (p == 4);
			phase_items = 0;
			while (phase_items < PHASE_WORDS) begin
				if ($urandom_range(99) < 15)
					put(3'($urandom_range(7)), $urandom, 1'($urandom_range(1)),
						1'($urandom_range(1)), 1'($urandom_range(1)));
				else
					add_session();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && due_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dpg_pkg.sv
src/dpg_thr.sv
src/dpg_core.sv
src/dosing_pump_runtime_guard.sv
tb/sv/dosing_pump_runtime_guard_tb.sv
